// ----- rtl/core/cpvc_pkg.sv -----
// Shared types, codes and constants of the cascaded position/velocity controller.
package cpvc_pkg;

  localparam int unsigned TIMEOUT_TICKS = 1000;
  localparam int unsigned CFG_IDX_W     = 4;
  localparam int unsigned CFG_DATA_W    = 32;

  // mode and status codes
  localparam logic [2:0] MODE_STOP  = 3'd0;
  localparam logic [2:0] MODE_POS   = 3'd1;
  localparam logic [2:0] MODE_VEL   = 3'd2;
  localparam logic [2:0] MODE_TRQ   = 3'd3;
  localparam logic [2:0] MODE_DUTY  = 3'd4;
  localparam logic [2:0] MODE_ESTOP = 3'd5;
  localparam logic [2:0] STAT_ALARM = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POS_GAIN   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_GAIN   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PLIM_HIGH  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PLIM_LOW   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT = 4'd7;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_PCLAMP,
    OP_PDIFF,
    OP_PDBAND,
    OP_PEDIFF,
    OP_MUL_PG,
    OP_ACC_SET,
    OP_MUL_DG,
    OP_ACC_SUB,
    OP_VCLAMP,
    OP_VLOAD,
    OP_VERR,
    OP_MUL_IG,
    OP_INTEG,
    OP_MUL_VG,
    OP_ACC_PI,
    OP_DUTY,
    OP_TORQUE
  } dp_op_e;

  typedef struct packed {
    logic   accept;
    dp_op_e op;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
  } dp_stat_t;

  typedef struct packed {
    logic               cmd_valid;
    logic [2:0]         req_type;
    logic signed [31:0] pos_ref;
    logic signed [31:0] vel_ref;
    logic signed [31:0] torque_ref;
    logic signed [15:0] duty_ref;
    logic signed [31:0] pos_meas;
    logic signed [31:0] vel_meas;
    logic               test_mode;
    logic               drive_alarm;
  } tick_t;

  typedef struct packed {
    logic signed [15:0] duty_out;
    logic [2:0]         status_code;
    logic               timed_out;
    logic               brake;
  } res_t;

endpackage

// ----- rtl/core/cpvc_ifs.sv -----
// Channel interfaces: tick input, result output and configuration write.
interface cpvc_tick_if import cpvc_pkg::*; ();
  logic  valid;
  logic  ready;
  tick_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cpvc_res_if import cpvc_pkg::*; ();
  logic valid;
  logic ready;
  res_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cpvc_cfg_if import cpvc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/cascaded_position_velocity_controller_unit.sv -----
// Cascaded position/velocity controller top level: one result per control tick.
// Position ticks run the position and velocity loops, velocity ticks the velocity loop,
// torque ticks the torque limit; stop, duty and emergency stop go straight to the result.
// All loop products go through one shared 33x31 multiplier, one product per step.
// Reset clears mode, integrator, watchdog, emergency and held references, and loads
// the configuration defaults; the block is ready as soon as reset is released.
module cascaded_position_velocity_controller_unit import cpvc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  cpvc_cfg_if.sink   cfg_i,
  cpvc_tick_if.sink  tick_i,
  cpvc_res_if.source res_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_i.ready = 1'b1;

  cpvc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_valid_i (tick_i.valid),
    .tick_ready_o (tick_i.ready),
    .res_valid_o  (res_o.valid),
    .res_ready_i  (res_o.ready),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  cpvc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .tick_i     (tick_i.data),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .res_o      (res_o.data)
  );

endmodule

// ----- rtl/core/cpvc_dp.sv -----
// Datapath: configuration, controller state, shared multiplier and result register.
module cpvc_dp import cpvc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  tick_t                 tick_i,
  input  dp_cmd_t               cmd_i,
  output dp_stat_t              stat_o,
  output res_t                  res_o
);

  function automatic logic [33:0] mag34(input logic signed [33:0] v);
    return v[33] ? 34'(-v) : 34'(v);
  endfunction

  // configuration
  logic [30:0]        pos_gain_q, deriv_gain_q, vel_gain_q, integ_gain_q, dead_band_q;
  logic signed [31:0] plim_hi_q, plim_lo_q;
  logic [14:0]        duty_lim_q;

  // controller state
  logic [2:0]         mode_q, mode_d, status_q, status_d;
  logic               emerg_q, emerg_d;
  logic [15:0]        wd_q, wd_d;
  logic signed [31:0] integ_q, integ_d, prev_q, prev_d;
  logic signed [31:0] hpos_q, hpos_d, hvel_q, hvel_d, htrq_q, htrq_d;
  logic signed [15:0] hduty_q, hduty_d;

  // work registers
  logic signed [31:0] pmeas_q, vmeas_q, ref_q, en_q;
  logic signed [32:0] diff_q, ed_q, w_q;
  logic signed [33:0] e2_q;
  logic [63:0]        prod_q;
  logic               psign_q;
  logic signed [49:0] acc_q;
  logic [31:0]        maxd_q;
  res_t               res_q;

  // tick entry: command latch, watchdog, mode
  logic [15:0] wd_c;
  logic        run_c;
  always_comb begin
    mode_d  = mode_q;
    emerg_d = emerg_q;
    integ_d = integ_q;
    hpos_d  = hpos_q;
    hvel_d  = hvel_q;
    htrq_d  = htrq_q;
    hduty_d = hduty_q;
    wd_c    = wd_q;
    if (tick_i.cmd_valid) begin
      wd_c = '0;
      unique case (tick_i.req_type) inside
        MODE_STOP: begin
          mode_d  = MODE_STOP;
          emerg_d = 1'b0;
        end
        MODE_POS, MODE_VEL: begin
          hpos_d = tick_i.pos_ref;
          hvel_d = tick_i.vel_ref;
          htrq_d = tick_i.torque_ref;
          mode_d = tick_i.req_type;
        end
        MODE_TRQ: begin
          htrq_d = tick_i.torque_ref;
          mode_d = MODE_TRQ;
        end
        MODE_DUTY: begin
          hduty_d = tick_i.duty_ref;
          mode_d  = MODE_DUTY;
        end
        default: mode_d = MODE_STOP;
      endcase
    end
    if (emerg_d) mode_d = MODE_ESTOP;
    if (!tick_i.test_mode && (32'(wd_c) > 32'(TIMEOUT_TICKS))) begin
      mode_d  = MODE_ESTOP;
      emerg_d = 1'b1;
    end
    status_d = (!tick_i.test_mode && tick_i.drive_alarm) ? STAT_ALARM : mode_d;
    run_c = (mode_d == MODE_POS) || (mode_d == MODE_VEL) ||
            (mode_d == MODE_TRQ) || (mode_d == MODE_DUTY);
    if (run_c) begin
      wd_d = (wd_c == 16'hFFFF) ? wd_c : wd_c + 16'd1;
    end else begin
      wd_d    = '0;
      integ_d = '0;
      hduty_d = '0;
    end
  end

  // shared multiplier
  logic [33:0] en_mag, ed_mag, e2_mag, diff_mag, trq_mag;
  logic [32:0] mul_mag;
  logic [30:0] mul_gain;
  logic        mul_neg, mul_en;
  logic [63:0] prod_d;
  always_comb begin
    en_mag   = mag34(34'(en_q));
    ed_mag   = mag34(34'(ed_q));
    e2_mag   = mag34(e2_q);
    diff_mag = mag34(34'(diff_q));
    trq_mag  = mag34(34'(htrq_q));
    mul_mag  = '0;
    mul_gain = '0;
    mul_neg  = 1'b0;
    mul_en   = 1'b1;
    case (cmd_i.op)
      OP_MUL_PG: begin
        mul_mag = en_mag[32:0]; mul_gain = pos_gain_q; mul_neg = en_q[31];
      end
      OP_MUL_DG: begin
        mul_mag = ed_mag[32:0]; mul_gain = deriv_gain_q; mul_neg = ed_q[32];
      end
      OP_MUL_IG: begin
        mul_mag = e2_mag[32:0]; mul_gain = integ_gain_q; mul_neg = e2_q[33];
      end
      OP_MUL_VG: begin
        mul_mag = e2_mag[32:0]; mul_gain = vel_gain_q; mul_neg = e2_q[33];
      end
      default: mul_en = 1'b0;
    endcase
    prod_d = 64'(mul_mag) * 64'(mul_gain);
  end

  logic signed [49:0] qprod;
  assign qprod = psign_q ? -$signed({2'b00, prod_q[63:16]}) : $signed({2'b00, prod_q[63:16]});

  // stage logic
  logic signed [31:0] ref_c, en_c;
  logic signed [33:0] diff34, db34, en34;
  logic signed [49:0] hv50, mx50, isum, iclamp, dclamp, wclamp;
  logic [31:0]        lim32, maxd_c;
  logic [49:0]        dmag50;
  logic [15:0]        tmag, lim16, tsel;
  logic signed [15:0] pi_duty, trq_duty;
  always_comb begin
    if (hpos_q > plim_hi_q)      ref_c = plim_hi_q;
    else if (hpos_q < plim_lo_q) ref_c = plim_lo_q;
    else                         ref_c = hpos_q;

    diff34 = 34'(diff_q);
    db34   = $signed({3'b000, dead_band_q});
    if (diff_mag <= 34'(db34))  en34 = '0;
    else if (diff34 > db34)     en34 = diff34 - db34;
    else                        en34 = diff34 + db34;
    if (en34 > 34'sh0_7FFF_FFFF)       en_c = 32'sh7FFF_FFFF;
    else if (en34 < -34'sh0_8000_0000) en_c = -32'sh8000_0000;
    else                               en_c = en34[31:0];

    hv50 = 50'(hvel_q);
    if (acc_q > hv50)       wclamp = hv50;
    else if (acc_q < -hv50) wclamp = -hv50;
    else                    wclamp = acc_q;

    lim32  = {1'b0, duty_lim_q, 16'h0000};
    maxd_c = (trq_mag[31:0] > lim32) ? lim32 : trq_mag[31:0];

    mx50 = $signed({18'h0, maxd_q});
    isum = 50'(integ_q) + qprod;
    if (isum > mx50)       iclamp = mx50;
    else if (isum < -mx50) iclamp = -mx50;
    else                   iclamp = isum;

    if (acc_q > mx50)       dclamp = mx50;
    else if (acc_q < -mx50) dclamp = -mx50;
    else                    dclamp = acc_q;
    dmag50  = dclamp[49] ? 50'(-dclamp) : 50'(dclamp);
    pi_duty = dclamp[49] ? -$signed({1'b0, dmag50[30:16]}) : $signed({1'b0, dmag50[30:16]});

    tmag     = trq_mag[31:16];
    lim16    = {1'b0, duty_lim_q};
    tsel     = (tmag > lim16) ? lim16 : tmag;
    trq_duty = htrq_q[31] ? -$signed(tsel) : $signed(tsel);
  end

  always_comb begin
    prev_d = prev_q;
    if (cmd_i.op == OP_PEDIFF) prev_d = en_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_gain_q   <= 31'd655360;
      deriv_gain_q <= '0;
      vel_gain_q   <= 31'd65536;
      integ_gain_q <= '0;
      plim_hi_q    <= 32'sd343129;
      plim_lo_q    <= -32'sd343129;
      dead_band_q  <= 31'd229;
      duty_lim_q   <= 15'h7FFF;
      mode_q       <= MODE_STOP;
      status_q     <= MODE_STOP;
      emerg_q      <= 1'b0;
      wd_q         <= '0;
      integ_q      <= '0;
      prev_q       <= '0;
      hpos_q       <= '0;
      hvel_q       <= '0;
      htrq_q       <= '0;
      hduty_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_POS_GAIN:   pos_gain_q   <= cfg_data_i[30:0];
          REG_DERIV_GAIN: deriv_gain_q <= cfg_data_i[30:0];
          REG_VEL_GAIN:   vel_gain_q   <= cfg_data_i[30:0];
          REG_INTEG_GAIN: integ_gain_q <= cfg_data_i[30:0];
          REG_PLIM_HIGH:  plim_hi_q    <= $signed(cfg_data_i);
          REG_PLIM_LOW:   plim_lo_q    <= $signed(cfg_data_i);
          REG_DEAD_BAND:  dead_band_q  <= cfg_data_i[30:0];
          REG_DUTY_LIMIT: duty_lim_q   <= cfg_data_i[14:0];
          default: ;
        endcase
      end
      prev_q <= prev_d;
      if (cmd_i.accept) begin
        mode_q   <= mode_d;
        status_q <= status_d;
        emerg_q  <= emerg_d;
        wd_q     <= wd_d;
        integ_q  <= integ_d;
        hpos_q   <= hpos_d;
        hvel_q   <= hvel_d;
        htrq_q   <= htrq_d;
        hduty_q  <= hduty_d;
      end else begin
        case (cmd_i.op)
          OP_INTEG:  integ_q <= iclamp[31:0];
          OP_DUTY:   hduty_q <= pi_duty;
          OP_TORQUE: hduty_q <= trq_duty;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      pmeas_q <= tick_i.pos_meas;
      vmeas_q <= tick_i.vel_meas;
    end
    if (mul_en) begin
      prod_q  <= prod_d;
      psign_q <= mul_neg;
    end
    case (cmd_i.op)
      OP_PCLAMP:  ref_q  <= ref_c;
      OP_PDIFF:   diff_q <= 33'(ref_q) - 33'(pmeas_q);
      OP_PDBAND:  en_q   <= en_c;
      OP_PEDIFF:  ed_q   <= 33'(en_q) - 33'(prev_q);
      OP_ACC_SET: acc_q  <= qprod;
      OP_ACC_SUB: acc_q  <= acc_q - qprod;
      OP_ACC_PI:  acc_q  <= qprod + 50'(integ_q);
      OP_VCLAMP:  w_q    <= wclamp[32:0];
      OP_VLOAD:   w_q    <= 33'(hvel_q);
      OP_VERR: begin
        e2_q   <= 34'(w_q) - 34'(vmeas_q);
        maxd_q <= maxd_c;
      end
      default: ;
    endcase
    if (cmd_i.out_load) begin
      res_q.duty_out    <= hduty_q;
      res_q.status_code <= status_q;
      res_q.timed_out   <= emerg_q;
      res_q.brake       <= (mode_q == MODE_STOP) || (mode_q == MODE_ESTOP);
    end
  end

  assign stat_o.mode = mode_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/core/cpvc_ctrl.sv -----
// Controller: sequences one control tick through the datapath and owns the tick and result handshakes.
module cpvc_ctrl import cpvc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     tick_valid_i,
  output logic     tick_ready_o,
  output logic     res_valid_o,
  input  logic     res_ready_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_ROUTE   = 5'd1;
  localparam logic [4:0] S_PCLAMP  = 5'd2;
  localparam logic [4:0] S_PDIFF   = 5'd3;
  localparam logic [4:0] S_PDBAND  = 5'd4;
  localparam logic [4:0] S_PEDIFF  = 5'd5;
  localparam logic [4:0] S_PMULP   = 5'd6;
  localparam logic [4:0] S_PACCP   = 5'd7;
  localparam logic [4:0] S_PMULD   = 5'd8;
  localparam logic [4:0] S_PACCD   = 5'd9;
  localparam logic [4:0] S_PVCLAMP = 5'd10;
  localparam logic [4:0] S_VLOAD   = 5'd11;
  localparam logic [4:0] S_VERR    = 5'd12;
  localparam logic [4:0] S_MULI    = 5'd13;
  localparam logic [4:0] S_INTEG   = 5'd14;
  localparam logic [4:0] S_MULV    = 5'd15;
  localparam logic [4:0] S_ACCPI   = 5'd16;
  localparam logic [4:0] S_DUTY    = 5'd17;
  localparam logic [4:0] S_TORQUE  = 5'd18;
  localparam logic [4:0] S_FIN     = 5'd19;

  logic [4:0] state_q, state_d;
  logic       res_valid_q, res_valid_d;
  logic       out_free;

  assign out_free     = !res_valid_q || res_ready_i;
  assign tick_ready_o = (state_q == S_IDLE);
  assign res_valid_o  = res_valid_q;

  always_comb begin
    state_d      = state_q;
    cmd_o.accept = 1'b0;
    cmd_o.op     = OP_NONE;
    cmd_o.out_load = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (tick_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_ROUTE;
        end
      end
      S_ROUTE: begin
        unique case (stat_i.mode)
          MODE_POS: state_d = S_PCLAMP;
          MODE_VEL: state_d = S_VLOAD;
          MODE_TRQ: state_d = S_TORQUE;
          default:  state_d = S_FIN;
        endcase
      end
      S_PCLAMP:  begin cmd_o.op = OP_PCLAMP;  state_d = S_PDIFF;   end
      S_PDIFF:   begin cmd_o.op = OP_PDIFF;   state_d = S_PDBAND;  end
      S_PDBAND:  begin cmd_o.op = OP_PDBAND;  state_d = S_PEDIFF;  end
      S_PEDIFF:  begin cmd_o.op = OP_PEDIFF;  state_d = S_PMULP;   end
      S_PMULP:   begin cmd_o.op = OP_MUL_PG;  state_d = S_PACCP;   end
      S_PACCP:   begin cmd_o.op = OP_ACC_SET; state_d = S_PMULD;   end
      S_PMULD:   begin cmd_o.op = OP_MUL_DG;  state_d = S_PACCD;   end
      S_PACCD:   begin cmd_o.op = OP_ACC_SUB; state_d = S_PVCLAMP; end
      S_PVCLAMP: begin cmd_o.op = OP_VCLAMP;  state_d = S_VERR;    end
      S_VLOAD:   begin cmd_o.op = OP_VLOAD;   state_d = S_VERR;    end
      S_VERR:    begin cmd_o.op = OP_VERR;    state_d = S_MULI;    end
      S_MULI:    begin cmd_o.op = OP_MUL_IG;  state_d = S_INTEG;   end
      S_INTEG:   begin cmd_o.op = OP_INTEG;   state_d = S_MULV;    end
      S_MULV:    begin cmd_o.op = OP_MUL_VG;  state_d = S_ACCPI;   end
      S_ACCPI:   begin cmd_o.op = OP_ACC_PI;  state_d = S_DUTY;    end
      S_DUTY:    begin cmd_o.op = OP_DUTY;    state_d = S_FIN;     end
      S_TORQUE:  begin cmd_o.op = OP_TORQUE;  state_d = S_FIN;     end
      S_FIN: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    res_valid_d = cmd_o.out_load || (res_valid_q && !res_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> out_free) else $error("result overwritten before transfer");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tick_valid_i && tick_ready_o) |=> !tick_ready_o) else $error("second tick taken");
  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> $past(state_q == S_FIN)) else $error("result without finish");
  a_pos_route: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUTE && stat_i.mode == MODE_POS) |=> (state_q == S_PCLAMP))
    else $error("position tick misrouted");
`endif

endmodule
